// ===== hdl/srts_pkg.sv =====
// Package for the sorted record table search block.
// Holds the table size, the record layout, the operation and status codes
// and the job and state types. No dependencies.
package srts_pkg;

  // Table size and the widths that follow from it.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int ID_W  = 24;
  localparam int AGE_W = 7;
  localparam int SAL_W = 24;

  // Operation codes on the input channel.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Status codes on the result channel.
  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // One stored record, salary in the low bits.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
    logic [SAL_W-1:0] salary;
  } record_t;

  localparam int REC_W = $bits(record_t);

  // Work classes that the front end hands to the back end.
  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_SEARCH,
    JOB_CLEAR
  } job_t;

  // One entry of the job queue.
  typedef struct packed {
    job_t    kind;
    record_t rec;
  } job_ent_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_INS_CMP,
    BK_INS_LAST,
    BK_SRCH_CMP,
    BK_DN_CMP,
    BK_UP_START,
    BK_UP_CMP,
    BK_FINISH,
    BK_NOTFOUND,
    BK_FULL
  } bk_state_t;

endpackage

// ===== hdl/srts_if.sv =====
// Valid/ready channel interfaces for the request and result sides.
// Depends on srts_pkg for the field widths.
interface srts_in_if import srts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [ID_W-1:0]  record_id;
  logic [AGE_W-1:0] age;
  logic [SAL_W-1:0] salary;

  modport source (output valid, operation, record_id, age, salary, input ready);
  modport sink   (input valid, operation, record_id, age, salary, output ready);
endinterface

interface srts_out_if import srts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ID_W-1:0]  record_id_res;
  logic [AGE_W-1:0] age_res;
  logic [SAL_W-1:0] salary_res;
  logic             last;

  modport source (output valid, status, record_id_res, age_res, salary_res, last,
                  input ready);
  modport sink   (input valid, status, record_id_res, age_res, salary_res, last,
                  output ready);
endinterface

// ===== hdl/srts_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module srts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/srts_front.sv =====
// Front end: accepts requests, classifies them into jobs and queues them.
// Depends on srts_pkg and the srts_in_if interface.
module srts_front import srts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  srts_in_if.sink  in_ch,
  output logic     q_vld,
  output job_ent_t q_ent,
  input  logic     q_pop
);

  job_ent_t   fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  logic       do_pop;
  job_ent_t   new_ent;
  logic       known_op;

  // Classify the incoming request. Unused codes are dropped here.
  always_comb begin
    new_ent.rec.id     = in_ch.record_id;
    new_ent.rec.age    = in_ch.age;
    new_ent.rec.salary = in_ch.salary;
    new_ent.kind       = JOB_LOAD;
    known_op           = 1'b1;
    case (in_ch.operation)
      OP_LOAD:   new_ent.kind = JOB_LOAD;
      OP_SEARCH: new_ent.kind = JOB_SEARCH;
      OP_CLEAR:  new_ent.kind = JOB_CLEAR;
      default:   known_op     = 1'b0;
    endcase
  end

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && known_op;
  assign q_vld       = (fill_r != 2'd0);
  assign q_ent       = fifo_r[rd_ptr_r];
  assign do_pop      = q_pop && q_vld;

  // Pointer and fill bookkeeping of the two-entry queue.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!push && do_pop) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_ent;
    end
  end

endmodule

// ===== hdl/srts_back.sv =====
// Back end: runs insertions and binary searches against the record RAM and
// drives the result register. Depends on srts_pkg, srts_ram and srts_out_if.
module srts_back import srts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_vld,
  input  job_ent_t  q_ent,
  output logic      q_pop,
  srts_out_if.source out_ch
);

  bk_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hp_r, hp_nxt;
  record_t          key_r, key_nxt;
  record_t          pend_r, pend_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [1:0]       out_status_r;
  record_t          out_rec_r;
  logic             out_last_r;

  logic             we;
  logic [IDX_W-1:0] waddr;
  record_t          wdata;
  logic [IDX_W-1:0] rd_addr;
  logic [REC_W-1:0] rdata_raw;
  record_t          rd;

  logic             emit;
  logic [1:0]       emit_status;
  record_t          emit_rec;
  logic             emit_last;
  logic             slot_free;

  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] lo_n, hp_n;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] up_j;

  srts_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata_raw)
  );

  assign rd        = record_t'(rdata_raw);
  assign slot_free = !out_vld_r || out_ch.ready;
  assign idx_ext   = CNT_W'(idx_r);

  // Sequencer: next state, RAM control and result emission.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    hit_nxt     = hit_r;
    lo_nxt      = lo_r;
    hp_nxt      = hp_r;
    key_nxt     = key_r;
    pend_nxt    = pend_r;
    rd_addr     = idx_r;
    we          = 1'b0;
    waddr       = idx_r;
    wdata       = key_r;
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_status = ST_MATCH;
    emit_rec    = pend_r;
    emit_last   = 1'b0;
    lo_n        = lo_r;
    hp_n        = hp_r;
    mid_sum     = '0;
    up_j        = CNT_W'(hit_r) + CNT_W'(1);

    case (state_r)
      BK_IDLE: begin
        if (q_vld) begin
          q_pop   = 1'b1;
          key_nxt = q_ent.rec;
          case (q_ent.kind)
            JOB_CLEAR: count_nxt = '0;
            JOB_LOAD: begin
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                state_nxt = BK_FULL;
              end else if (count_r == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = q_ent.rec;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                idx_nxt   = IDX_W'(count_r - CNT_W'(1));
                rd_addr   = IDX_W'(count_r - CNT_W'(1));
                state_nxt = BK_INS_CMP;
              end
            end
            JOB_SEARCH: begin
              if (count_r == '0) begin
                state_nxt = BK_NOTFOUND;
              end else begin
                lo_nxt    = '0;
                hp_nxt    = count_r;
                mid_sum   = {1'b0, count_r} - (CNT_W+1)'(1);
                idx_nxt   = IDX_W'(mid_sum >> 1);
                rd_addr   = IDX_W'(mid_sum >> 1);
                state_nxt = BK_SRCH_CMP;
              end
            end
            default: ;
          endcase
        end
      end

      // Shift the entry below the hole up while its salary is greater.
      BK_INS_CMP: begin
        we    = 1'b1;
        waddr = IDX_W'(idx_ext + CNT_W'(1));
        if (rd.salary > key_r.salary) begin
          wdata = rd;
          if (idx_r == '0) begin
            state_nxt = BK_INS_LAST;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
            rd_addr = idx_r - IDX_W'(1);
          end
        end else begin
          wdata     = key_r;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = BK_IDLE;
        end
      end

      BK_INS_LAST: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = key_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = BK_IDLE;
      end

      // One binary search probe per cycle; hp holds the upper bound plus one.
      BK_SRCH_CMP: begin
        if (rd.salary == key_r.salary) begin
          pend_nxt = rd;
          hit_nxt  = idx_r;
          if (idx_r == '0) begin
            state_nxt = BK_UP_START;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            rd_addr   = idx_r - IDX_W'(1);
            state_nxt = BK_DN_CMP;
          end
        end else begin
          if (rd.salary < key_r.salary) begin
            lo_n = idx_ext + CNT_W'(1);
          end else begin
            hp_n = idx_ext;
          end
          lo_nxt = lo_n;
          hp_nxt = hp_n;
          if (lo_n < hp_n) begin
            mid_sum = {1'b0, lo_n} + {1'b0, hp_n} - (CNT_W+1)'(1);
            idx_nxt = IDX_W'(mid_sum >> 1);
            rd_addr = IDX_W'(mid_sum >> 1);
          end else begin
            state_nxt = BK_NOTFOUND;
          end
        end
      end

      // Walk down over equal salaries, one entry per cycle while the result register is free.
      BK_DN_CMP: begin
        if (rd.salary == key_r.salary) begin
          if (slot_free) begin
            emit     = 1'b1;
            pend_nxt = rd;
            if (idx_r == '0) begin
              state_nxt = BK_UP_START;
            end else begin
              idx_nxt = idx_r - IDX_W'(1);
              rd_addr = idx_r - IDX_W'(1);
            end
          end
        end else begin
          state_nxt = BK_UP_START;
        end
      end

      BK_UP_START: begin
        if (up_j < count_r) begin
          idx_nxt   = IDX_W'(up_j);
          rd_addr   = IDX_W'(up_j);
          state_nxt = BK_UP_CMP;
        end else begin
          state_nxt = BK_FINISH;
        end
      end

      // Walk up over equal salaries, one entry per cycle while the result register is free.
      BK_UP_CMP: begin
        if (rd.salary == key_r.salary) begin
          if (slot_free) begin
            emit     = 1'b1;
            pend_nxt = rd;
            if ((idx_ext + CNT_W'(1)) < count_r) begin
              idx_nxt = idx_r + IDX_W'(1);
              rd_addr = idx_r + IDX_W'(1);
            end else begin
              state_nxt = BK_FINISH;
            end
          end
        end else begin
          state_nxt = BK_FINISH;
        end
      end

      // The held match is the final result of the search.
      BK_FINISH: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          state_nxt = BK_IDLE;
        end
      end

      BK_NOTFOUND: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_status = ST_NOTFOUND;
          emit_rec    = '0;
          emit_last   = 1'b1;
          state_nxt   = BK_IDLE;
        end
      end

      BK_FULL: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_status = ST_FULL;
          emit_rec    = '0;
          emit_last   = 1'b1;
          state_nxt   = BK_IDLE;
        end
      end

      default: state_nxt = BK_IDLE;
    endcase
  end

  // Result register occupancy.
  always_comb begin
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Working registers of the current job.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    hit_r  <= hit_nxt;
    lo_r   <= lo_nxt;
    hp_r   <= hp_nxt;
    key_r  <= key_nxt;
    pend_r <= pend_nxt;
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_rec_r    <= emit_rec;
      out_last_r   <= emit_last;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.record_id_res = out_rec_r.id;
  assign out_ch.age_res       = out_rec_r.age;
  assign out_ch.salary_res    = out_rec_r.salary;
  assign out_ch.last          = out_last_r;

endmodule

// ===== hdl/sorted_record_table_search.sv =====
// Top level of the sorted record table search block.
// Depends on srts_pkg, srts_if, srts_front, srts_back and srts_ram.
//
// The block keeps up to TABLE_DEPTH records in ascending salary order in a
// single-port-read RAM, equal salaries in arrival order. A request is queued
// by the front end (two entries deep) and executed by the back end, one
// request at a time. A load is dispatched, then each stored entry with a
// greater salary is shifted up, then the new record is written; the RAM,
// with one read and one write port, shifts entries one per cycle. A load
// into an empty table is written at dispatch, and a load into a full table
// gives a full status. A search is dispatched, then runs its binary search
// probes, at most log2(TABLE_DEPTH) + 1 of them. A miss then gives its
// result. A hit walks the equal entries down, turns to walk them up and
// then closes, each walk ending at the table edge or on a different salary,
// all gated by the result register being taken. A clear is done at
// dispatch. Results come one per cycle at best, the hit first, then lower
// equal entries going down, then higher ones going up, with last set on the
// final one. Unused operation codes are dropped without a result.
module sorted_record_table_search import srts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  srts_in_if.sink    in_ch,
  srts_out_if.source out_ch
);

  logic     q_vld;
  job_ent_t q_ent;
  logic     q_pop;

  // Request intake and job queue.
  srts_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_vld (q_vld),
    .q_ent (q_ent),
    .q_pop (q_pop)
  );

  // Table execution and result output.
  srts_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_ent  (q_ent),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== verif/srts_reply_checker.sv =====
// Reply checker for the sorted record table search block.
// Watches both channels, keeps its own copy of the record table and compares each reply.
// Depends on srts_pkg and the channel interfaces in srts_if.
module srts_reply_checker import srts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  srts_in_if          in_mon,
  srts_out_if         out_mon,
  output int unsigned err_count,
  output int unsigned pending,
  output int unsigned replies_seen,
  output int unsigned longest_run
);
  timeunit 1ns;
  timeprecision 1ps;

  // One reply as it appears on the result channel.
  typedef struct packed {
    logic [1:0] status;
    record_t    rec;
    logic       last;
  } reply_t;

  // Shadow copy of the table and the replies still owed by the block.
  record_t     shadow_tbl [TABLE_DEPTH];
  int          shadow_cnt = 0;
  reply_t      owed_replies [$];
  reply_t      got_reply;
  reply_t      want_reply;
  record_t     req_rec;

  // Applies one request to the shadow table and queues the replies it causes.
  function automatic void apply_request(input logic [1:0] op, input record_t rec);
    reply_t hits [$];
    reply_t r;
    int     lo;
    int     hi;
    int     mid;
    int     hit;
    int     pos;
    int     i;
    r = '0;
    case (op)
      OP_LOAD: begin
        if (shadow_cnt >= TABLE_DEPTH) begin
          // Full table: the record is dropped and one status reply comes back.
          r.status = ST_FULL;
          r.last   = 1'b1;
          owed_replies.push_back(r);
        end else begin
          // Insertion: only strictly greater salaries move up, so ties keep arrival order.
          pos = shadow_cnt;
          while (pos > 0 && shadow_tbl[pos-1].salary > rec.salary) begin
            shadow_tbl[pos] = shadow_tbl[pos-1];
            pos--;
          end
          shadow_tbl[pos] = rec;
          shadow_cnt++;
        end
      end
      OP_SEARCH: begin
        lo  = 0;
        hi  = shadow_cnt - 1;
        hit = -1;
        while (lo <= hi && hit < 0) begin
          mid = (lo + hi) / 2;
          if (shadow_tbl[mid].salary == rec.salary) begin
            hit = mid;
          end else if (shadow_tbl[mid].salary < rec.salary) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
          r.last   = 1'b1;
          owed_replies.push_back(r);
        end else begin
          // Landing entry first, then equal entries below, then equal entries above.
          r.status = ST_MATCH;
          r.rec    = shadow_tbl[hit];
          hits.push_back(r);
          i = hit - 1;
          while (i >= 0 && shadow_tbl[i].salary == rec.salary) begin
            r.rec = shadow_tbl[i];
            hits.push_back(r);
            i--;
          end
          i = hit + 1;
          while (i < shadow_cnt && shadow_tbl[i].salary == rec.salary) begin
            r.rec = shadow_tbl[i];
            hits.push_back(r);
            i++;
          end
          hits[hits.size()-1].last = 1'b1;
          if (hits.size() > longest_run) longest_run = hits.size();
          foreach (hits[k]) owed_replies.push_back(hits[k]);
        end
      end
      OP_CLEAR: shadow_cnt = 0;
      default: ;
    endcase
  endfunction

  // Counts a failure and prints the first few in full.
  function automatic void note_error(input string what, input reply_t want, input reply_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected status=%0d id=%h age=%0d salary=%h last=%0d",
               want.status, want.rec.id, want.rec.age, want.rec.salary, want.last);
      $display("  actual   status=%0d id=%h age=%0d salary=%h last=%0d",
               got.status, got.rec.id, got.rec.age, got.rec.salary, got.last);
    end
  endfunction

  // Replies are checked before the request of the same edge is applied.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        got_reply.status     = out_mon.status;
        got_reply.rec.id     = out_mon.record_id_res;
        got_reply.rec.age    = out_mon.age_res;
        got_reply.rec.salary = out_mon.salary_res;
        got_reply.last       = out_mon.last;
        replies_seen++;
        if (owed_replies.size() == 0) begin
          note_error("reply with no request waiting for it", '0, got_reply);
        end else begin
          want_reply = owed_replies.pop_front();
          if (got_reply.status     !== want_reply.status     ||
              got_reply.rec.id     !== want_reply.rec.id     ||
              got_reply.rec.age    !== want_reply.rec.age    ||
              got_reply.rec.salary !== want_reply.rec.salary ||
              got_reply.last       !== want_reply.last) begin
            note_error("reply mismatch", want_reply, got_reply);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        req_rec.id     = in_mon.record_id;
        req_rec.age    = in_mon.age;
        req_rec.salary = in_mon.salary;
        apply_request(in_mon.operation, req_rec);
      end
      pending = owed_replies.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Top of the testbench for the sorted record table search block.
// Drives directed and random requests with random stalls on both sides.
// Depends on srts_pkg, srts_if, the block itself and srts_reply_checker.
module tb import srts_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         RANDOM_ITEMS = 220;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 3 * TABLE_DEPTH + 20;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int unsigned err_count;
  int unsigned pending;
  int unsigned replies_seen;
  int unsigned longest_run;

  // Stimulus bookkeeping.
  int          phase      = 0;
  bit          random_on  = 1'b0;
  bit          rx_hold    = 1'b0;
  int unsigned rand_cnt   = 0;
  int unsigned n_load     = 0;
  int unsigned n_search   = 0;
  int unsigned n_clear    = 0;
  int unsigned n_unused   = 0;
  int unsigned cycle_cnt  = 0;
  logic [SAL_W-1:0] sal_pool [8];

  always #10 clk = ~clk;

  srts_in_if  in_ch ();
  srts_out_if out_ch ();

  sorted_record_table_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  srts_reply_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .err_count    (err_count),
    .pending      (pending),
    .replies_seen (replies_seen),
    .longest_run  (longest_run)
  );

  // Idle rates per phase: receiver-heavy, then sender-heavy, then none.
  function automatic int tx_idle_pct();
    return (phase == 0) ? 38 : (phase == 1) ? 58 : 0;
  endfunction

  function automatic int rx_idle_pct();
    return (phase == 0) ? 58 : (phase == 1) ? 38 : 0;
  endfunction

  // Mostly salaries from a small pool so that ties and hits are common.
  function automatic logic [SAL_W-1:0] pick_salary();
    int unsigned      r;
    logic [SAL_W-1:0] s;
    r = $urandom_range(99);
    s = sal_pool[3'($urandom_range(7))];
    if (r < 15) begin
      s = SAL_W'($urandom);
    end else if (r < 30) begin
      s = $urandom_range(1) ? s + 1'b1 : s - 1'b1;
    end
    return s;
  endfunction

  // Offers one request and waits until the block takes it.
  task automatic send_req(input logic [1:0] op, input logic [ID_W-1:0] id,
                          input logic [AGE_W-1:0] age, input logic [SAL_W-1:0] sal);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.record_id <= id;
    in_ch.age       <= age;
    in_ch.salary    <= sal;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (op)
      OP_LOAD:   n_load++;
      OP_SEARCH: n_search++;
      OP_CLEAR:  n_clear++;
      default:   n_unused++;
    endcase
    if (random_on && op != OP_UNUSED) begin
      rand_cnt++;
      phase = (rand_cnt * 3 / RANDOM_ITEMS > 2) ? 2 : rand_cnt * 3 / RANDOM_ITEMS;
    end
  endtask

  // Clears the table, fills it mostly with one salary, searches and overloads it.
  task automatic fill_table();
    logic [SAL_W-1:0] s;
    s = sal_pool[3'($urandom_range(7))];
    send_req(OP_CLEAR, ID_W'($urandom), AGE_W'($urandom_range(127)), SAL_W'($urandom));
    repeat (TABLE_DEPTH) begin
      send_req(OP_LOAD, ID_W'($urandom), AGE_W'($urandom_range(127)),
               ($urandom_range(3) == 0) ? pick_salary() : s);
    end
    send_req(OP_SEARCH, ID_W'($urandom), AGE_W'($urandom_range(127)), s);
    send_req(OP_LOAD, ID_W'($urandom), AGE_W'($urandom_range(127)), pick_salary());
    send_req(OP_SEARCH, ID_W'($urandom), AGE_W'($urandom_range(127)), pick_salary());
  endtask

  // Receiver: random ready, forced low while the long hold-off runs.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct());
    end
  end

  // Long receiver hold-off early in the last phase, so the block backs up.
  initial begin
    wait (phase == 2);
    repeat (20) @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d replies still owed", cycle_cnt, pending);
    $display("DONE: errors detected");
    $finish;
  end

  // Main stimulus.
  initial begin
    int unsigned r;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.record_id = '0;
    in_ch.age       = '0;
    in_ch.salary    = '0;
    sal_pool[0] = '0;
    sal_pool[1] = '1;
    for (int k = 2; k < 8; k++) sal_pool[k] = SAL_W'($urandom);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty search, unused code, field extremes, ties, misses and clear.
    send_req(OP_SEARCH, 24'h000000, 7'd0, 24'h000000);
    send_req(OP_UNUSED, 24'hFFFFFF, 7'd127, 24'hFFFFFF);
    send_req(OP_LOAD, 24'hFFFFFF, 7'd127, 24'hFFFFFF);
    send_req(OP_LOAD, 24'h000000, 7'd0, 24'h000000);
    send_req(OP_LOAD, 24'h000001, 7'd5, 24'h000100);
    send_req(OP_LOAD, 24'h000002, 7'd6, 24'h000100);
    send_req(OP_LOAD, 24'h000003, 7'd7, 24'h000100);
    send_req(OP_LOAD, 24'h000004, 7'd8, 24'h000080);
    send_req(OP_SEARCH, 24'h000000, 7'd0, 24'h000100);
    send_req(OP_SEARCH, 24'hFFFFFF, 7'd127, 24'h000000);
    send_req(OP_SEARCH, 24'h000000, 7'd0, 24'hFFFFFF);
    send_req(OP_SEARCH, 24'h000000, 7'd0, 24'h000101);
    send_req(OP_SEARCH, 24'h000000, 7'd0, 24'h0000FF);
    send_req(OP_SEARCH, 24'h000000, 7'd0, 24'h000080);
    send_req(OP_CLEAR, 24'h000000, 7'd0, 24'h000000);
    send_req(OP_SEARCH, 24'h000000, 7'd0, 24'h000100);
    send_req(OP_LOAD, 24'hA5A5A5, 7'd85, 24'h5A5A5A);
    send_req(OP_SEARCH, 24'h000000, 7'd0, 24'h5A5A5A);

    // Random part: a full-table sequence first, then a weighted mix.
    random_on = 1'b1;
    fill_table();
    while (rand_cnt < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 2) begin
        fill_table();
      end else if (r < 50) begin
        send_req(OP_LOAD, ID_W'($urandom), AGE_W'($urandom_range(127)), pick_salary());
      end else if (r < 90) begin
        send_req(OP_SEARCH, ID_W'($urandom), AGE_W'($urandom_range(127)), pick_salary());
      end else if (r < 95) begin
        send_req(OP_CLEAR, ID_W'($urandom), AGE_W'($urandom_range(127)), SAL_W'($urandom));
        sal_pool[3'($urandom_range(7, 2))] = SAL_W'($urandom);
      end else begin
        send_req(OP_UNUSED, ID_W'($urandom), AGE_W'($urandom_range(127)), SAL_W'($urandom));
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d searches, %0d clears and %0d unused codes;",
             n_load, n_search, n_clear, n_unused);
    $display("checked %0d replies, longest match run %0d, in %0d cycles.",
             replies_seen, longest_run, cycle_cnt);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
